### rtl/idw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idw_pkg
// Shared types, register indexes and fixed-point constants of the IDW block.
// ----------------------------------------------------------------------------
package idw_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int INTENSITY_WIDTH_DEF = 16;
    localparam int RECIP_FRAC_BITS_DEF = 32;

    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = 64;
    localparam int D_W        = 17;
    localparam int ENTRY_W    = 16;
    localparam int VAL_W      = 20;
    localparam int OUT_DATA_W = 24;
    localparam int DIV_N_W    = 80;
    localparam int DIV_D_W    = 64;
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int MANT_W     = 31;
    localparam int LG_W       = 26;
    localparam int SQ_STEPS   = 20;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_NEGATIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW_C    = 3'd6;

    localparam logic [1:0] DMODE_EUCLID  = 2'd1;
    localparam logic [1:0] DMODE_SQ_RSQ  = 2'd2;
    localparam logic [1:0] METRIC_DIAG   = 2'd1;
    localparam logic [1:0] METRIC_FULL   = 2'd2;

    localparam logic [15:0]       RADIUS_RST = 16'd2560;
    localparam logic [CFG_W-1:0]  ROW_A_RST  = 48'd4096;
    localparam logic [CFG_W-1:0]  ROW_B_RST  = 48'd268435456;
    localparam logic [CFG_W-1:0]  ROW_C_RST  = 48'd17592186044416;

    localparam logic [30:0]       LN2_Q30     = 31'd744261118;
    localparam logic signed [D_W-1:0] OFS_LIMIT = 17'sd65535;

    typedef enum logic [4:0] {
        S_IDLE, S_DD, S_DDW, S_EMW, S_DIST, S_SQRT, S_RSQ, S_THR, S_RDIV,
        S_PMUL, S_PMH, S_PACC, S_FIN, S_QDIV, S_NORM, S_SQ, S_SQW, S_LN, S_LNW, S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/idw_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idw_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module idw_mul #(
    parameter int A_W = 50,
    parameter int B_W = 32
) (
    input  wire                         i_clk,
    input  wire  signed [A_W-1:0]       i_a,
    input  wire  signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

endmodule
`default_nettype wire

### rtl/idw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idw_div
    import idw_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire  [DIV_N_W-1:0]      i_dividend,
    input  wire  [DIV_D_W-1:0]      i_divisor,
    output logic [DIV_N_W-1:0]      o_quot,
    output t_unit_sts               o_sts
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W:0]   r_rem;
    logic [DIV_N_W-1:0] r_quot;
    logic [DIV_D_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_D_W:0]   rem_sh;
    logic               ge;

    assign rem_sh = {r_rem[DIV_D_W-1:0], r_quot[DIV_N_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sh - {1'b0, r_div} : rem_sh;
            r_quot <= {r_quot[DIV_N_W-2:0], ge};
        end
    end

    assign o_quot     = r_quot;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
`default_nettype wire

### rtl/idw_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idw_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module idw_sqrt
    import idw_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire  [SQRT_IN_W-1:0]    i_value,
    output logic [SQRT_OUT_W-1:0]   o_root,
    output t_unit_sts               o_sts
);

    logic [SQRT_IN_W-1:0] r_v;
    logic [SQRT_IN_W-1:0] r_res;
    logic [SQRT_IN_W-1:0] r_bit;
    logic                 r_busy;
    logic                 r_done;
    logic [SQRT_IN_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit >> 2) == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(SQRT_IN_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root     = r_res[SQRT_OUT_W-1:0];
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
`default_nettype wire

### rtl/idw_point_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idw_point_interpolator
// Inverse-distance-weighted interpolation of one query from scattered samples.
//
// Input stream: each beat carries the query and sample positions, intensity
// and has_sample in tdata, first_item in tuser, last_item in tlast. The block
// takes one beat, works on it under a sequencer that drives one multiplier,
// one restoring divider and one square-root unit, then takes the next.
// Per sample: the metric terms go through the shared multiplier, then the
// square root (Euclidean mode only) and the reciprocal division in the
// bit-serial divider. A beat without a sample goes straight to the finish.
// On last_item the result takes a further division, a normalization and
// repeated squaring for the logarithm.
// The result sits in an output register; while the receiver stalls, the next
// result waits in the sequencer and no new beat is taken.
// Reset restores the register defaults and clears both sums and all valids.
// ----------------------------------------------------------------------------
module idw_point_interpolator
    import idw_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = INTENSITY_WIDTH_DEF,
    parameter int RECIP_FRAC_BITS = RECIP_FRAC_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [CFG_W-1:0]          i_cfg_data,
    input  wire                       i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // query_x, query_y, query_z, sample_x, sample_y, sample_z,
    // sample_intensity, has_sample, zero fill
    input  wire  [((6*COORD_WIDTH+INTENSITY_WIDTH+1+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire                       i_s_axis_tuser,   // first_item
    input  wire                       i_s_axis_tlast,   // last_item
    output logic                      o_m_axis_tvalid,
    input  wire                       i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]     o_m_axis_tdata,   // interpolated_value, zero fill
    output logic                      o_m_axis_tuser    // no_contribution
);

    localparam int CW  = COORD_WIDTH;
    localparam int IW  = INTENSITY_WIDTH;
    localparam int OW  = (CW + 1 > 18) ? CW + 1 : 18;
    localparam int RCW = RECIP_FRAC_BITS + 17;
    localparam int MA  = 34;
    localparam int MB  = (IW > 32) ? IW : 32;
    localparam int PW  = MA + MB;
    localparam int FW  = RCW + MB + 1;
    localparam logic [RCW-1:0] RECIP_ONE = {1'b1, {(RCW-1){1'b0}}};
    localparam logic signed [FW-1:0] P_MAX = FW'($signed({1'b0, {(SUM_W-1){1'b1}}}));
    localparam logic signed [FW-1:0] P_MIN = FW'($signed({1'b1, {(SUM_W-1){1'b0}}}));

    function automatic logic signed [D_W-1:0] ofs(
        input logic [CW-1:0] q,
        input logic [CW-1:0] s
    );
        logic signed [OW-1:0] dq;
        dq = OW'($signed(q)) - OW'($signed(s));
        if (dq > OW'(OFS_LIMIT)) return OFS_LIMIT;
        if (dq < -OW'(OFS_LIMIT)) return -OFS_LIMIT;
        return dq[D_W-1:0];
    endfunction

    logic [1:0]        r_dmode, r_metric;
    logic              r_reject;
    logic [15:0]       r_radius;
    logic [CFG_W-1:0]  r_row_a, r_row_b, r_row_c;

    t_state r_state, n_state;
    logic signed [D_W-1:0]   r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic signed [IW-1:0]    r_inten, n_inten;
    logic                    r_last, n_last;
    logic [1:0]              r_i, r_j, n_i, n_j;
    logic signed [SUM_W-1:0] r_acc, n_acc, r_dist, n_dist;
    logic signed [SUM_W-1:0] r_wis, n_wis, r_ws, n_ws;
    logic                    r_neg, n_neg;
    logic [RCW-1:0]          r_recip, n_recip;
    logic signed [PW-1:0]    r_plo, n_plo;
    logic [55:0]             r_norm, n_norm;
    logic [5:0]              r_p, n_p;
    logic [MANT_W-1:0]       r_mant, n_mant;
    logic [LG_W-1:0]         r_lg, n_lg;
    logic [4:0]              r_cnt, n_cnt;
    logic [VAL_W-1:0]        r_res_val, n_res_val;
    logic                    r_res_flag, n_res_flag;
    logic                    r_ovalid;
    logic                    out_load;

    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic                    div_start, sqrt_start;
    logic [DIV_N_W-1:0]      div_dividend, div_q;
    logic [DIV_D_W-1:0]      div_divisor;
    logic [SQRT_IN_W-1:0]    sqrt_in;
    logic [SQRT_OUT_W-1:0]   sqrt_res;
    t_unit_sts               div_sts, sqrt_sts;

    logic                    s_fire;
    logic signed [D_W-1:0]   d_i, d_j;
    logic signed [ENTRY_W-1:0] ent;
    logic [CFG_W-1:0]        row;
    logic                    full, diag, last_term;
    logic [1:0]              adv_i, adv_j;
    logic signed [SUM_W-1:0] dist_v, prod64, w64;
    logic [SUM_W-1:0]        mag;
    logic [31:0]             thr;
    logic signed [FW-1:0]    pv;
    logic [31:0]             m2;
    logic [LG_W-1:0]         lg2;
    logic [57:0]             lsum;

    assign s_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign full   = (r_metric == METRIC_FULL);
    assign diag   = (r_metric == METRIC_DIAG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmode  <= '0;
            r_metric <= '0;
            r_reject <= 1'b0;
            r_radius <= RADIUS_RST;
            r_row_a  <= ROW_A_RST;
            r_row_b  <= ROW_B_RST;
            r_row_c  <= ROW_C_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DISTANCE_MODE:   r_dmode  <= i_cfg_data[1:0];
                REG_METRIC_MODE:     r_metric <= i_cfg_data[1:0];
                REG_REJECT_NEGATIVE: r_reject <= i_cfg_data[0];
                REG_RADIUS:          r_radius <= i_cfg_data[15:0];
                REG_MATRIX_ROW_A:    r_row_a  <= i_cfg_data;
                REG_MATRIX_ROW_B:    r_row_b  <= i_cfg_data;
                REG_MATRIX_ROW_C:    r_row_c  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_i)
            2'd0:    d_i = r_dx;
            2'd1:    d_i = r_dy;
            default: d_i = r_dz;
        endcase
        case (r_j)
            2'd0:    d_j = r_dx;
            2'd1:    d_j = r_dy;
            default: d_j = r_dz;
        endcase
        case (r_i)
            2'd0:    row = r_row_a;
            2'd1:    row = r_row_b;
            default: row = r_row_c;
        endcase
        case (r_j)
            2'd0:    ent = row[15:0];
            2'd1:    ent = row[31:16];
            default: ent = row[47:32];
        endcase
        if (full) begin
            last_term = (r_i == 2'd2) && (r_j == 2'd2);
            adv_i     = (r_j == 2'd2) ? r_i + 2'd1 : r_i;
            adv_j     = (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
        end else begin
            last_term = (r_i == 2'd2);
            adv_i     = r_i + 2'd1;
            adv_j     = r_i + 2'd1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_dz       = r_dz;
        n_inten    = r_inten;
        n_last     = r_last;
        n_i        = r_i;
        n_j        = r_j;
        n_acc      = r_acc;
        n_dist     = r_dist;
        n_wis      = r_wis;
        n_ws       = r_ws;
        n_neg      = r_neg;
        n_recip    = r_recip;
        n_plo      = r_plo;
        n_norm     = r_norm;
        n_p        = r_p;
        n_mant     = r_mant;
        n_lg       = r_lg;
        n_cnt      = r_cnt;
        n_res_val  = r_res_val;
        n_res_flag = r_res_flag;
        o_s_axis_tready = 1'b0;
        out_load     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_start   = 1'b0;
        sqrt_in      = '0;
        dist_v = '0;
        mag    = '0;
        thr    = '0;
        pv     = '0;
        prod64 = '0;
        w64    = '0;
        m2     = '0;
        lg2    = '0;
        lsum   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_dx    = ofs(i_s_axis_tdata[0*CW +: CW], i_s_axis_tdata[3*CW +: CW]);
                    n_dy    = ofs(i_s_axis_tdata[1*CW +: CW], i_s_axis_tdata[4*CW +: CW]);
                    n_dz    = ofs(i_s_axis_tdata[2*CW +: CW], i_s_axis_tdata[5*CW +: CW]);
                    n_inten = $signed(i_s_axis_tdata[6*CW +: IW]);
                    n_last  = i_s_axis_tlast;
                    n_acc   = '0;
                    n_i     = 2'd0;
                    n_j     = 2'd0;
                    if (i_s_axis_tuser) begin
                        n_wis = '0;
                        n_ws  = '0;
                    end
                    n_state = i_s_axis_tdata[6*CW+IW] ? S_DD : S_FIN;
                end
            end
            S_DD: begin
                mul_a   = MA'(d_j);
                mul_b   = MB'(d_i);
                n_state = S_DDW;
            end
            S_DDW: begin
                if (full || diag) begin
                    mul_a   = MA'($signed(mul_p[33:0]));
                    mul_b   = MB'(ent);
                    n_state = S_EMW;
                end else begin
                    n_acc   = r_acc + $signed(mul_p[SUM_W-1:0]);
                    n_i     = adv_i;
                    n_j     = adv_j;
                    n_state = last_term ? S_DIST : S_DD;
                end
            end
            S_EMW: begin
                n_acc   = r_acc + $signed(mul_p[SUM_W-1:0]);
                n_i     = adv_i;
                n_j     = adv_j;
                n_state = last_term ? S_DIST : S_DD;
            end
            S_DIST: begin
                dist_v = (full || diag) ? (r_acc >>> 12) : r_acc;
                n_dist = dist_v;
                if (r_dmode == DMODE_EUCLID) begin
                    if (dist_v[SUM_W-1]) begin
                        n_state = S_FIN;
                    end else begin
                        sqrt_start = 1'b1;
                        sqrt_in    = {dist_v[SQRT_IN_W-17:0], 16'b0};
                        n_state    = S_SQRT;
                    end
                end else begin
                    n_state = S_RSQ;
                end
            end
            S_SQRT: begin
                if (sqrt_sts.done) begin
                    n_dist  = SUM_W'(sqrt_res);
                    n_state = S_RSQ;
                end
            end
            S_RSQ: begin
                mul_a   = MA'($signed({1'b0, r_radius}));
                mul_b   = MB'($signed({1'b0, r_radius}));
                n_state = S_THR;
            end
            S_THR: begin
                thr = (r_dmode == DMODE_SQ_RSQ) ? mul_p[31:0] : {8'b0, r_radius, 8'b0};
                mag = r_dist[SUM_W-1] ? SUM_W'(-r_dist) : SUM_W'(r_dist);
                if (!(r_dist < $signed({32'b0, thr})) || (r_reject && r_inten[IW-1])) begin
                    n_state = S_FIN;
                end else begin
                    n_neg = r_dist[SUM_W-1];
                    if (mag == '0) begin
                        n_recip = RECIP_ONE;
                        n_state = S_PMUL;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = DIV_N_W'(RECIP_ONE);
                        div_divisor  = mag;
                        n_state      = S_RDIV;
                    end
                end
            end
            S_RDIV: begin
                if (div_sts.done) begin
                    n_recip = div_q[RCW-1:0];
                    n_state = S_PMUL;
                end
            end
            S_PMUL: begin
                mul_a   = MA'($signed({1'b0, r_recip[31:0]}));
                mul_b   = MB'(r_inten);
                n_state = S_PMH;
            end
            S_PMH: begin
                n_plo   = mul_p;
                mul_a   = MA'($signed({1'b0, r_recip[RCW-1:32]}));
                mul_b   = MB'(r_inten);
                n_state = S_PACC;
            end
            S_PACC: begin
                pv = (FW'(mul_p) <<< 32) + FW'(r_plo);
                pv = r_neg ? -pv : pv;
                if (pv > P_MAX) begin
                    prod64 = P_MAX[SUM_W-1:0];
                end else if (pv < P_MIN) begin
                    prod64 = P_MIN[SUM_W-1:0];
                end else begin
                    prod64 = pv[SUM_W-1:0];
                end
                w64     = SUM_W'($signed({1'b0, r_recip}));
                w64     = r_neg ? -w64 : w64;
                n_wis   = sat_add(r_wis, prod64);
                n_ws    = sat_add(r_ws, w64);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_wis <= 0 || r_ws <= 0 || r_wis <= r_ws) begin
                    n_res_val  = '0;
                    n_res_flag = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {r_wis, 16'b0};
                    div_divisor  = r_ws;
                    n_state      = S_QDIV;
                end
            end
            S_QDIV: begin
                if (div_sts.done) begin
                    n_norm  = (div_q[DIV_N_W-1:56] != '0) ? '1 : div_q[55:0];
                    n_p     = 6'd55;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_norm[55]) begin
                    n_mant  = r_norm[55:25];
                    n_lg    = LG_W'(r_p - 6'd16);
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    n_norm = {r_norm[54:0], 1'b0};
                    n_p    = r_p - 6'd1;
                end
            end
            S_SQ: begin
                mul_a   = MA'($signed({1'b0, r_mant}));
                mul_b   = MB'($signed({1'b0, r_mant}));
                n_state = S_SQW;
            end
            S_SQW: begin
                m2  = mul_p[61:30];
                lg2 = {r_lg[LG_W-2:0], 1'b0};
                if (m2[31]) begin
                    n_mant = m2[31:1];
                    lg2[0] = 1'b1;
                end else begin
                    n_mant = m2[30:0];
                end
                n_lg    = lg2;
                n_cnt   = r_cnt + 5'd1;
                n_state = (r_cnt == 5'(SQ_STEPS - 1)) ? S_LN : S_SQ;
            end
            S_LN: begin
                mul_a   = MA'($signed({1'b0, r_lg}));
                mul_b   = MB'($signed({1'b0, LN2_Q30}));
                n_state = S_LNW;
            end
            S_LNW: begin
                lsum       = mul_p[57:0] + {24'b0, 1'b1, 33'b0};
                n_res_val  = (lsum[57:54] != '0) ? '1 : lsum[53:34];
                n_res_flag = 1'b0;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wis    <= '0;
            r_ws     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wis   <= n_wis;
            r_ws    <= n_ws;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dz       <= n_dz;
        r_inten    <= n_inten;
        r_last     <= n_last;
        r_i        <= n_i;
        r_j        <= n_j;
        r_acc      <= n_acc;
        r_dist     <= n_dist;
        r_neg      <= n_neg;
        r_recip    <= n_recip;
        r_plo      <= n_plo;
        r_norm     <= n_norm;
        r_p        <= n_p;
        r_mant     <= n_mant;
        r_lg       <= n_lg;
        r_cnt      <= n_cnt;
        r_res_val  <= n_res_val;
        r_res_flag <= n_res_flag;
        if (out_load) begin
            o_m_axis_tdata <= OUT_DATA_W'(r_res_val);
            o_m_axis_tuser <= r_res_flag;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;

    idw_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    idw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_q),
        .o_sts      (div_sts)
    );

    idw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sqrt_in),
        .o_root  (sqrt_res),
        .o_sts   (sqrt_sts)
    );

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_sts.busy)
        else $error("square root started while busy");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tuser) |=> (r_wis == '0 && r_ws == '0))
        else $error("first beat did not clear the sums");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no_contribution with nonzero value");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_sts.busy || sqrt_sts.busy) |-> !o_s_axis_tready)
        else $error("input taken while a unit is busy");

endmodule
`default_nettype wire

### dv/tb_idw_point_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idw_point_interpolator
// Self-checking bench for the IDW point interpolator. Streams queries of
// scattered samples under several register settings, predicts each
// interpolated log value in a scoreboard and compares every result beat.
// ----------------------------------------------------------------------------
module tb_idw_point_interpolator;
    import idw_pkg::*;

    localparam int IN_W      = ((6*16+16+1+7)/8)*8;
    localparam int IDLE_MAX  = 5000;
    localparam int DRAIN_CYC = 400;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [15:0] qx, qy, qz, sx, sy, sz, inten;
        logic        has, first, last;
    } t_point;

    class idw_scoreboard;
        logic [1:0]  dist_mode, metric;
        logic        reject;
        logic [15:0] radius;
        logic [47:0] row_a, row_b, row_c;
        longint      wsum_int, wsum;
        logic [19:0] exp_val[$];
        logic        exp_none[$];
        int          errors;

        function new();
            dist_mode = 0; metric = 0; reject = 0; radius = RADIUS_RST;
            row_a = ROW_A_RST; row_b = ROW_B_RST; row_c = ROW_C_RST;
            wsum_int = 0; wsum = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] v);
            case (idx)
                REG_DISTANCE_MODE:   dist_mode = v[1:0];
                REG_METRIC_MODE:     metric = v[1:0];
                REG_REJECT_NEGATIVE: reject = v[0];
                REG_RADIUS:          radius = v[15:0];
                REG_MATRIX_ROW_A:    row_a = v;
                REG_MATRIX_ROW_B:    row_b = v;
                REG_MATRIX_ROW_C:    row_c = v;
                default: ;
            endcase
        endfunction

        function longint coef(int k);
            logic [47:0] row;
            row = (k < 3) ? row_a : (k < 6) ? row_b : row_c;
            return longint'($signed(row[(k%3)*16 +: 16]));
        endfunction

        function longint sat_sum(longint a, longint b);
            longint s;
            s = a + b;
            if (b > 0 && s < a) return 64'sh7fffffffffffffff;
            if (b < 0 && s > a) return 64'sh8000000000000000;
            return s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void add_sample(t_point it);
            longint d[3];
            longint dval, acc, thr, inten, w, prod;
            longint unsigned mag, recip, ui;
            logic neg, pneg;
            d[0] = longint'($signed(it.qx)) - longint'($signed(it.sx));
            d[1] = longint'($signed(it.qy)) - longint'($signed(it.sy));
            d[2] = longint'($signed(it.qz)) - longint'($signed(it.sz));
            acc = 0;
            if (metric == METRIC_DIAG) begin
                for (int i = 0; i < 3; i++) acc += coef(4*i) * (d[i]*d[i]);
                dval = acc >>> 12;
            end else if (metric == METRIC_FULL) begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) acc += coef(3*i+j) * (d[j]*d[i]);
                dval = acc >>> 12;
            end else begin
                dval = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
            end
            if (dist_mode == DMODE_EUCLID) begin
                if (dval < 0) return;
                dval = longint'(int_sqrt(longint'(dval) << 16));
            end
            thr = (dist_mode == DMODE_SQ_RSQ) ? longint'(radius) * longint'(radius)
                                              : longint'(radius) << 8;
            if (!(dval < thr)) return;
            inten = longint'($signed(it.inten));
            if (reject && inten < 0) return;
            neg = dval < 0;
            mag = neg ? -dval : dval;
            recip = 64'd1 << 48;
            if (mag != 0) recip = recip / mag;
            w = neg ? -longint'(recip) : longint'(recip);
            ui = (inten < 0) ? -inten : inten;
            pneg = (inten < 0) != neg;
            if (ui != 0 && recip > 64'h7fffffffffffffff / ui)
                prod = pneg ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
            else
                prod = pneg ? -longint'(recip*ui) : longint'(recip*ui);
            wsum_int = sat_sum(wsum_int, prod);
            wsum = sat_sum(wsum, w);
        endfunction

        function logic [19:0] ln_ratio(longint unsigned num, longint unsigned den);
            longint unsigned q, r, frac, ratio, m, lg, val;
            int p;
            q = num / den;
            r = num % den;
            frac = 0;
            if (q > (64'd1 << 40) - 1) begin
                ratio = (64'd1 << 56) - 1;
            end else begin
                for (int i = 0; i < 16; i++) begin
                    r <<= 1;
                    frac <<= 1;
                    if (r >= den) begin
                        r -= den;
                        frac |= 1;
                    end
                end
                ratio = (q << 16) | frac;
            end
            p = 63;
            while (p > 0 && !ratio[p]) p--;
            m = (p > 30) ? ratio >> (p-30) : ratio << (30-p);
            lg = p - 16;
            for (int i = 0; i < SQ_STEPS; i++) begin
                m = (m*m) >> 30;
                lg <<= 1;
                if (m >= (64'd1 << 31)) begin
                    m >>= 1;
                    lg |= 1;
                end
            end
            val = (lg * 64'd744261118 + (64'd1 << 33)) >> 34;
            if (val > 64'hfffff) val = 64'hfffff;
            return val[19:0];
        endfunction

        function void note_beat(t_point it);
            if (it.first) begin
                wsum_int = 0;
                wsum = 0;
            end
            if (it.has) add_sample(it);
            if (!it.last) return;
            if (wsum_int <= 0 || wsum <= 0 || wsum_int <= wsum) begin
                exp_val.push_back(0);
                exp_none.push_back(1);
            end else begin
                exp_val.push_back(ln_ratio(wsum_int, wsum));
                exp_none.push_back(0);
            end
        endfunction

        function void check_result(logic [19:0] val, logic none);
            if (exp_val.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat value=%0d flag=%0b", val, none);
                return;
            end
            if (val !== exp_val[0] || none !== exp_none[0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value=%0d flag=%0b, got value=%0d flag=%0b",
                             exp_val[0], exp_none[0], val, none);
            end
            void'(exp_val.pop_front());
            void'(exp_none.pop_front());
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 0;
    logic                 i_s_axis_tlast = 0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    idw_scoreboard sb = new();
    bit   idle_on = 1;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   scale = 512;

    idw_point_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            t_point it;
            it.qx = i_s_axis_tdata[15:0];   it.qy = i_s_axis_tdata[31:16];
            it.qz = i_s_axis_tdata[47:32];  it.sx = i_s_axis_tdata[63:48];
            it.sy = i_s_axis_tdata[79:64];  it.sz = i_s_axis_tdata[95:80];
            it.inten = i_s_axis_tdata[111:96];
            it.has = i_s_axis_tdata[112];
            it.first = i_s_axis_tuser;
            it.last = i_s_axis_tlast;
            sb.note_beat(it);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[VAL_W-1:0], o_m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_m_axis_tready <= 0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            i_m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [47:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        sb.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (sb.exp_val.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_beat(t_point it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= {7'd0, it.has, it.inten, it.sz, it.sy, it.sx, it.qz, it.qy, it.qx};
        i_s_axis_tuser <= it.first;
        i_s_axis_tlast <= it.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic stop_stream();
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] near(logic [15:0] q);
        int v;
        v = int'($signed(q)) + $urandom_range(0, 2*scale) - scale;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_point make_point(logic [15:0] qx, qy, qz, bit first, bit last);
        t_point it;
        it.qx = qx; it.qy = qy; it.qz = qz;
        it.sx = near(qx); it.sy = near(qy); it.sz = near(qz);
        it.inten = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
        it.has = ($urandom_range(0, 11) != 0);
        it.first = first;
        it.last = last;
        return it;
    endfunction

    task automatic send_query();
        logic [15:0] qx, qy, qz;
        int n;
        bit first;
        qx = 16'($urandom()); qy = 16'($urandom()); qz = 16'($urandom());
        n = $urandom_range(1, 6);
        first = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < n; i++) begin
            t_point it;
            it = make_point(qx, qy, qz, first && i == 0, i == n-1);
            if ($urandom_range(0, 19) == 0) begin
                it.sx = 16'($urandom()); it.sy = 16'($urandom()); it.sz = 16'($urandom());
                it.first = 1'($urandom()); it.last = 1'($urandom());
            end
            send_beat(it);
        end
    endtask

    function automatic logic [47:0] rand_row(int diag);
        logic [47:0] r;
        r = {16'($urandom_range(0, 1200) - 600), 16'($urandom_range(0, 1200) - 600),
             16'($urandom_range(0, 1200) - 600)};
        r[diag*16 +: 16] = 16'($urandom_range(1000, 9000));
        if ($urandom_range(0, 4) == 0) r = 48'({$urandom(), $urandom()});
        return r;
    endfunction

    task automatic set_phase(logic [1:0] dm, logic [1:0] mm, logic rj, logic [15:0] rad,
                             bit rand_mat, int sc);
        cfg_write(REG_DISTANCE_MODE, 48'(dm));
        cfg_write(REG_METRIC_MODE, 48'(mm));
        cfg_write(REG_REJECT_NEGATIVE, 48'(rj));
        cfg_write(REG_RADIUS, 48'(rad));
        if (rand_mat) begin
            cfg_write(REG_MATRIX_ROW_A, rand_row(0));
            cfg_write(REG_MATRIX_ROW_B, rand_row(1));
            cfg_write(REG_MATRIX_ROW_C, rand_row(2));
        end else begin
            cfg_write(REG_MATRIX_ROW_A, ROW_A_RST);
            cfg_write(REG_MATRIX_ROW_B, ROW_B_RST);
            cfg_write(REG_MATRIX_ROW_C, ROW_C_RST);
        end
        scale = sc;
    endtask

    task automatic directed();
        t_point it;
        it = '{16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300, 16'd100,
               1'b1, 1'b1, 1'b0};
        send_beat(it);
        it.sx = 16'h0180; it.inten = 16'h7fff; it.first = 0;
        send_beat(it);
        it.sx = 16'h0080; it.inten = 16'h8000;
        send_beat(it);
        it.has = 0; it.last = 1;
        send_beat(it);
        it = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'd5,
               1'b1, 1'b1, 1'b1};
        send_beat(it);
        it = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0,
               1'b1, 1'b1, 1'b1};
        send_beat(it);
        it = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'd30000,
               1'b1, 1'b1, 1'b0};
        send_beat(it);
        it.sz = 16'h0600; it.inten = 16'd1; it.first = 0; it.last = 1;
        send_beat(it);
        it = '{16'h0010, 16'h0020, 16'h0030, 16'h0000, 16'h0000, 16'h0000, 16'hffff,
               1'b0, 1'b1, 1'b1};
        send_beat(it);
        it.has = 1; it.first = 0;
        send_beat(it);
        it.inten = 16'd2000;
        send_beat(it);
        stop_stream();
    endtask

    initial begin
        logic [1:0] dms[8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0};
        logic [1:0] mms[8] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0};
        logic [15:0] rads[8] = '{16'd65535, 16'd3000, 16'd1000, 16'd0, 16'd65535,
                                 16'd500, 16'd4000, 16'd2560};
        int scs[8] = '{4096, 700, 600, 256, 65535, 300, 900, 512};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed();
        drain();
        cfg_write(REG_REJECT_NEGATIVE, 48'd1);
        cfg_write(REG_UNUSED, 48'hffffffffffff);
        directed();
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            set_phase(dms[ph], mms[ph], ph[0], rads[ph], ph != 7 && ph != 4, scs[ph]);
            if (ph == 7) idle_on = 0;
            for (int k = 0; k < 58; k++) send_query();
            stop_stream();
            drain();
        end
        while (sb.exp_val.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_val.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
